@@ src/dabd_pkg.sv @@
// Package: types and constants of the DPCM audio block decoder.
`timescale 1ns / 1ps
package dabd_pkg;

   localparam logic OP_START  = 1'b0;
   localparam logic OP_DECODE = 1'b1;

   localparam logic [1:0] REG_LEVEL  = 2'd0;
   localparam logic [1:0] REG_RUN_EN = 2'd1;
   localparam logic [1:0] REG_STEREO = 2'd2;
   localparam logic [1:0] REG_WIDE   = 2'd3;

   localparam logic [2:0] TYPE_ZERO   = 3'd0;
   localparam logic [2:0] TYPE_ESCAPE = 3'd7;

   localparam logic [2:0] LEVEL_SPLIT   = 3'd3;
   localparam logic [3:0] TYPE_BITS     = 4'd3;
   localparam logic [3:0] ESC_BITS      = 4'd4;
   localparam logic [3:0] ESC_WIDTH     = 4'd8;
   localparam logic [3:0] ESC_SHIFT     = 4'd9;
   localparam logic [3:0] HI_WIDTH_BASE = 4'd3;
   localparam logic [3:0] HI_SHIFT_BASE = 4'd1;
   localparam logic [3:0] LO_WIDTH_BASE = 4'd5;
   localparam logic [3:0] LO_SHIFT_BASE = 4'd2;
   localparam logic [3:0] RUN_ONE_BITS  = 4'd4;
   localparam logic [3:0] RUN_TWO_BITS  = 4'd6;
   localparam logic [3:0] RUN_LONG_BITS = 4'd14;
   localparam logic [1:0] RUN_LONG_CODE = 2'd3;

   typedef struct packed {
      logic        op;
      logic [15:0] first_sample;
      logic [15:0] second_sample;
      logic [15:0] bit_window;
   } req_type;

   typedef struct packed {
      logic [15:0] sample;
      logic        channel;
      logic [3:0]  bits_used;
   } rsp_type;

   typedef struct packed {
      logic [1:0] index;
      logic [7:0] data;
   } csr_type;

   typedef struct packed {
      logic [2:0] quant_level;
      logic       run_length_enable;
      logic       stereo;
      logic       wide_samples;
   } cfg_type;

   typedef struct packed {
      logic [1:0][15:0] predictor;
      logic             active_channel;
      logic [7:0]       run_remaining;
   } state_type;

endpackage

@@ src/dabd_if.sv @@
// Interfaces: valid/ready channels for requests, results and register writes.
`timescale 1ns / 1ps
interface dabd_req_if;
   import dabd_pkg::*;
   logic    valid;
   logic    ready;
   req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface dabd_rsp_if;
   import dabd_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface dabd_csr_if;
   import dabd_pkg::*;
   logic    valid;
   logic    ready;
   csr_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ src/dabd_step.sv @@
// Decode step: next predictor state and result for one registered item.
`timescale 1ns / 1ps
module dabd_step import dabd_pkg::*; (
   input  cfg_type   cfg,
   input  state_type st,
   input  req_type   item,
   output state_type st_next,
   output rsp_type   result
);

   always_comb begin
      logic [15:0] win;
      logic        ch;
      logic [15:0] p;
      logic [2:0]  kind;
      logic [3:0]  nb;
      logic [3:0]  sh;
      logic [3:0]  pos;
      logic [12:0] field;
      logic        sign;
      logic [9:0]  mag_raw;
      logic [15:0] mag;
      logic        apply;
      logic [15:0] mask;

      win     = item.bit_window;
      ch      = st.active_channel;
      p       = st.predictor[ch];
      kind    = win[2:0];
      nb      = '0;
      sh      = '0;
      pos     = '0;
      field   = '0;
      apply   = 1'b0;
      mask    = cfg.wide_samples ? 16'hFFFF : 16'h00FF;
      st_next = st;

      if (st.run_remaining != 8'd0) begin
         st_next.run_remaining = st.run_remaining - 8'd1;
      end else if (kind == TYPE_ESCAPE) begin
         if (win[3]) begin
            p   = '0;
            pos = ESC_BITS;
         end else begin
            apply = 1'b1;
            field = {1'b0, win[15:4]};
            nb    = ESC_WIDTH;
            sh    = ESC_SHIFT;
            if (cfg.quant_level < LEVEL_SPLIT) begin
               nb = ESC_WIDTH - {1'b0, cfg.quant_level};
               sh = ESC_SHIFT + {1'b0, cfg.quant_level};
            end
            pos = ESC_BITS + nb;
         end
      end else if (kind != TYPE_ZERO) begin
         apply = 1'b1;
         field = win[15:3];
         if (cfg.quant_level >= LEVEL_SPLIT) begin
            nb = HI_WIDTH_BASE + {1'b0, cfg.quant_level};
            sh = HI_SHIFT_BASE + {1'b0, kind};
         end else begin
            nb = LO_WIDTH_BASE - {1'b0, cfg.quant_level};
            sh = LO_SHIFT_BASE + {1'b0, kind} + {1'b0, cfg.quant_level};
         end
         pos = TYPE_BITS + nb;
      end else if (cfg.run_length_enable) begin
         if (!win[3]) begin
            st_next.run_remaining = '0;
            pos = RUN_ONE_BITS;
         end else if (win[5:4] != RUN_LONG_CODE) begin
            st_next.run_remaining = {6'd0, win[5:4]};
            pos = RUN_TWO_BITS;
         end else begin
            st_next.run_remaining = win[13:6];
            pos = RUN_LONG_BITS;
         end
      end else begin
         pos = TYPE_BITS;
      end

      sign    = field[nb - 4'd1];
      mag_raw = field[9:0] & ((10'd1 << (nb - 4'd1)) - 10'd1);
      mag     = {6'd0, mag_raw} << sh;
      if (apply) begin
         p = sign ? (p - mag) : (p + mag);
      end

      if (item.op == OP_START) begin
         st_next.predictor[0]   = item.first_sample & mask;
         st_next.predictor[1]   = item.second_sample & mask;
         st_next.run_remaining  = '0;
         st_next.active_channel = 1'b0;
      end else begin
         st_next.predictor[ch]  = p;
         st_next.active_channel = cfg.stereo ? ~ch : ch;
      end

      result.sample    = p & mask;
      result.channel   = ch;
      result.bits_used = pos;
   end

endmodule

@@ src/dpcm_audio_block_decoder_core.sv @@
// Top level: DPCM audio block decoder with input stage, decode step and result register.
//
//   channel  dir  payload                                          accepted when
//   req_ch   in   op, first_sample, second_sample, bit_window      valid && ready
//   rsp_ch   out  sample, channel, bits_used                       valid && ready
//   csr_ch   in   index (0 level, 1 run enable, 2 stereo, 3 wide)  valid && ready
//
// One item per cycle unless a stalled result holds the input stage: an item is
// registered there, decoded, and its result is registered and offered on rsp_ch.
// The predictor and run counter update when the item is decoded, which closes the loop.
// Start items give no result. Synchronous reset clears state; registers reset
// with wide samples on. A stalled result holds the input stage only for decode items.
`timescale 1ns / 1ps
module dpcm_audio_block_decoder_core import dabd_pkg::*; (
   input logic         clock,
   input logic         reset,
   dabd_req_if.sink    req_ch,
   dabd_rsp_if.source  rsp_ch,
   dabd_csr_if.sink    csr_ch
);

   cfg_type   cfg_ff,       cfg_in;
   state_type state_ff,     state_in;
   logic      in_valid_ff,  in_valid_in;
   req_type   in_ff;
   logic      rsp_valid_ff, rsp_valid_in;
   rsp_type   rsp_ff;
   rsp_type   step_rsp;
   logic      fire;
   logic      fire_decode;

   dabd_step u_step (
      .cfg     (cfg_ff),
      .st      (state_ff),
      .item    (in_ff),
      .st_next (state_in),
      .result  (step_rsp)
   );

   assign fire        = in_valid_ff && ((in_ff.op == OP_START) || !rsp_valid_ff || rsp_ch.ready);
   assign fire_decode = fire && (in_ff.op == OP_DECODE);

   assign req_ch.ready = !in_valid_ff || fire;
   assign csr_ch.ready = 1'b1;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.payload = rsp_ff;

   assign in_valid_in  = req_ch.valid || (in_valid_ff && !fire);
   assign rsp_valid_in = fire_decode || (rsp_valid_ff && !rsp_ch.ready);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.payload.index)
            REG_LEVEL:  cfg_in.quant_level       = csr_ch.payload.data[2:0];
            REG_RUN_EN: cfg_in.run_length_enable = csr_ch.payload.data[0];
            REG_STEREO: cfg_in.stereo            = csr_ch.payload.data[0];
            REG_WIDE:   cfg_in.wide_samples      = csr_ch.payload.data[0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '{quant_level: 3'd0, run_length_enable: 1'b0,
                           stereo: 1'b0, wide_samples: 1'b1};
         state_ff     <= '0;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_ff <= req_ch.payload;
      end
      if (fire_decode) begin
         rsp_ff <= step_rsp;
      end
   end

   a_run_no_bits: assert property (@(posedge clock) disable iff (reset)
      fire_decode && (state_ff.run_remaining != 8'd0) |-> step_rsp.bits_used == 4'd0)
      else $error("run sample consumed stream bits");

   a_start_clears: assert property (@(posedge clock) disable iff (reset)
      fire && (in_ff.op == OP_START) |=> state_ff.run_remaining == 8'd0
         && !state_ff.active_channel)
      else $error("start item left run count or channel set");

   a_mono_channel: assert property (@(posedge clock) disable iff (reset)
      fire_decode && !cfg_ff.stereo |=> state_ff.active_channel == $past(state_ff.active_channel))
      else $error("channel toggled in mono");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> in_valid_ff && rsp_valid_ff && !rsp_ch.ready)
      else $error("input stalled without a blocked result");

   a_bits_bound: assert property (@(posedge clock) disable iff (reset)
      fire_decode |-> step_rsp.bits_used <= RUN_LONG_BITS)
      else $error("bit count beyond window");

endmodule

@@ tb/tb_dpcm_audio_block_decoder_core.sv @@
`timescale 1ns / 1ps
// Testbench: directed and random DPCM streams through the block decoder, each sample checked against a mirror.
module tb_dpcm_audio_block_decoder_core;
   import dabd_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 1000000;
   localparam int          PHASES      = 12;
   localparam int          PHASE_ITEMS = 100;
   localparam int          HOLD_CYCLES = 150;

   class sample_predictor;
      cfg_type     cfg;
      logic [15:0] predictor [2];
      logic        active_channel;
      logic [7:0]  run_left;
      rsp_type     expected_samples [$];
      int          errors;

      function new();
         cfg.quant_level = 3'd0;
         cfg.run_length_enable = 1'b0;
         cfg.stereo = 1'b0;
         cfg.wide_samples = 1'b1;
         predictor[0] = '0;
         predictor[1] = '0;
         active_channel = 1'b0;
         run_left = '0;
         errors = 0;
      endfunction

      function void write_reg(csr_type w);
         case (w.index)
            REG_LEVEL:  cfg.quant_level = w.data[2:0];
            REG_RUN_EN: cfg.run_length_enable = w.data[0];
            REG_STEREO: cfg.stereo = w.data[0];
            REG_WIDE:   cfg.wide_samples = w.data[0];
            default: ;
         endcase
      endfunction

      static function int unsigned field(int unsigned win, int unsigned pos, int unsigned n);
         return (win >> pos) & ((32'd1 << n) - 32'd1);
      endfunction

      static function logic [15:0] add_delta(logic [15:0] p, int unsigned code,
                                             int unsigned nb, int unsigned sh);
         int unsigned mag;
         mag = (code & ((32'd1 << (nb - 1)) - 32'd1)) << sh;
         if (((code >> (nb - 1)) & 32'd1) != 0) return p - mag[15:0];
         return p + mag[15:0];
      endfunction

      function void accept_item(req_type r);
         logic [15:0] mask;
         logic [15:0] p;
         logic [2:0]  kind;
         logic        ch;
         int unsigned win, pos, nb, sh, lvl, code;
         rsp_type     e;
         mask = cfg.wide_samples ? 16'hFFFF : 16'h00FF;
         if (r.op == OP_START) begin
            predictor[0] = r.first_sample & mask;
            predictor[1] = r.second_sample & mask;
            run_left = '0;
            active_channel = 1'b0;
            return;
         end
         win = r.bit_window;
         pos = 0;
         ch = active_channel;
         p = predictor[ch];
         lvl = cfg.quant_level;
         if (run_left != 8'd0) begin
            run_left = run_left - 8'd1;
         end else begin
            kind = r.bit_window[2:0];
            pos = 3;
            if (kind == TYPE_ESCAPE) begin
               pos = 4;
               if (r.bit_window[3]) begin
                  p = '0;
               end else begin
                  nb = (lvl < 3) ? 8 - lvl : 8;
                  sh = (lvl < 3) ? 9 + lvl : 9;
                  p = add_delta(p, field(win, pos, nb), nb, sh);
                  pos += nb;
               end
            end else if (kind != TYPE_ZERO) begin
               nb = (lvl >= 3) ? 3 + lvl : 5 - lvl;
               sh = (lvl >= 3) ? 1 + kind : 2 + kind + lvl;
               p = add_delta(p, field(win, pos, nb), nb, sh);
               pos += nb;
            end else if (cfg.run_length_enable) begin
               code = field(win, pos, 1);
               pos += 1;
               if (code == 1) begin
                  code = field(win, pos, 2);
                  pos += 2;
                  if (code == RUN_LONG_CODE) begin
                     code = field(win, pos, 8);
                     pos += 8;
                  end
               end
               run_left = code[7:0];
            end
         end
         predictor[ch] = p;
         e.sample = p & mask;
         e.channel = ch;
         e.bits_used = pos[3:0];
         expected_samples = {expected_samples, e};
         if (cfg.stereo) active_channel = ~ch;
      endfunction

      task report(string msg);
         $display("%0t mismatch: %s", $time, msg);
         errors++;
      endtask

      task check_sample(rsp_type got);
         rsp_type e;
         if (expected_samples.size() == 0) begin
            report($sformatf("sample %h ch %0d bits %0d with nothing pending",
                             got.sample, got.channel, got.bits_used));
            return;
         end
         e = expected_samples.pop_front();
         if (got.sample !== e.sample)
            report($sformatf("sample %h, want %h", got.sample, e.sample));
         if (got.channel !== e.channel)
            report($sformatf("channel %b, want %b", got.channel, e.channel));
         if (got.bits_used !== e.bits_used)
            report($sformatf("bits_used %0d, want %0d", got.bits_used, e.bits_used));
      endtask
   endclass

   logic            clock = 1'b0;
   logic            reset;
   bit              tx_calm;
   bit              rx_calm;
   bit              hold_request;
   int unsigned     cycle_count;
   sample_predictor mirror;

   dabd_req_if req_ch ();
   dabd_rsp_if rsp_ch ();
   dabd_csr_if csr_ch ();

   dpcm_audio_block_decoder_core i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) mirror.accept_item(req_ch.payload);
         if (csr_ch.valid && csr_ch.ready) mirror.write_reg(csr_ch.payload);
         if (rsp_ch.valid && rsp_ch.ready) mirror.check_sample(rsp_ch.payload);
      end
   end

   function automatic int unsigned pick_gap(bit calm);
      int unsigned r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(20, 60);
   endfunction

   function automatic req_type start_item(logic [15:0] first, logic [15:0] second);
      req_type r;
      r.op = OP_START;
      r.first_sample = first;
      r.second_sample = second;
      r.bit_window = 16'($urandom);
      return r;
   endfunction

   function automatic req_type decode_item(logic [15:0] w);
      req_type r;
      r.op = OP_DECODE;
      r.first_sample = 16'($urandom);
      r.second_sample = 16'($urandom);
      r.bit_window = w;
      return r;
   endfunction

   // Keep long runs mostly short so they do not swamp the stream.
   function automatic logic [15:0] random_window();
      logic [15:0] w;
      w = 16'($urandom);
      if ($urandom_range(0, 7) == 0) w[2:0] = TYPE_ZERO;
      if (w[2:0] == TYPE_ZERO && w[5:3] == 3'b111 && $urandom_range(0, 5) != 0)
         w[13:6] = 8'($urandom_range(0, 6));
      return w;
   endfunction

   task automatic send_item(req_type r);
      int unsigned gap;
      gap = pick_gap(tx_calm);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.payload <= r;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (mirror.expected_samples.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_regs(logic [2:0] lvl, logic run_en, logic st, logic wide);
      csr_type w [4];
      w[0].index = REG_LEVEL;
      w[0].data = {5'($urandom), lvl};
      w[1].index = REG_RUN_EN;
      w[1].data = {7'($urandom), run_en};
      w[2].index = REG_STEREO;
      w[2].data = {7'($urandom), st};
      w[3].index = REG_WIDE;
      w[3].data = {7'($urandom), wide};
      foreach (w[i]) begin
         csr_ch.valid <= 1'b1;
         csr_ch.payload <= w[i];
         do @(posedge clock); while (!csr_ch.ready);
      end
      csr_ch.valid <= 1'b0;
   endtask

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      int unsigned gap;
      do @(posedge clock); while (reset);
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
            rsp_ch.ready <= 1'b1;
         end else begin
            gap = ($urandom_range(0, 3) == 0) ? pick_gap(rx_calm) : 0;
            if (gap != 0) begin
               rsp_ch.ready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      logic [15:0] w;
      logic [2:0]  lvl;
      logic        run_en, st, wide;
      mirror = new();
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.payload = '0;
      tx_calm = 1'b0;
      rx_calm = 1'b0;
      hold_request = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      program_regs(3'd0, 1'b1, 1'b1, 1'b1);
      send_item(start_item(16'h8000, 16'h7FFF));
      send_item(decode_item(16'h000F));
      send_item(decode_item(16'h07F7));
      send_item(decode_item(16'h0FF7));
      for (int t = 1; t < 7; t++) begin
         w = 16'($urandom);
         w[2:0] = 3'(t);
         send_item(decode_item(w));
      end
      send_item(start_item(16'hFFFF, 16'h0000));
      send_item(decode_item(16'h0000));
      send_item(decode_item(16'h0018));
      send_item(decode_item(16'hFFFF));
      send_item(decode_item(16'h0028));
      send_item(decode_item(16'h1234));
      send_item(decode_item(16'hFFFF));
      send_item(decode_item(16'h0038));
      send_item(decode_item(16'h00F8));
      for (int i = 0; i < 3; i++) send_item(decode_item(16'($urandom)));
      send_item(decode_item(16'hFFFF));
      send_item(start_item(16'h0000, 16'hFFFF));
      send_item(decode_item(16'hFFF1));
      send_item(decode_item(16'h0001));
      drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: {lvl, run_en, st, wide} = {3'd0, 1'b0, 1'b0, 1'b1};
            1: {lvl, run_en, st, wide} = {3'd5, 1'b1, 1'b1, 1'b1};
            2: {lvl, run_en, st, wide} = {3'd7, 1'b1, 1'b1, 1'b0};
            3: {lvl, run_en, st, wide} = {3'd3, 1'b1, 1'b0, 1'b1};
            4: {lvl, run_en, st, wide} = {3'd6, 1'b0, 1'b1, 1'b0};
            5: {lvl, run_en, st, wide} = {3'd2, 1'b1, 1'b1, 1'b1};
            6: {lvl, run_en, st, wide} = {3'd1, 1'b1, 1'b0, 1'b0};
            7: {lvl, run_en, st, wide} = {3'd4, 1'b0, 1'b1, 1'b1};
            default: {lvl, run_en, st, wide} = 6'($urandom);
         endcase
         program_regs(lvl, run_en, st, wide);
         tx_calm = ($urandom_range(0, 4) == 0);
         rx_calm = ($urandom_range(0, 4) == 0);
         if (ph == 2) begin
            tx_calm = 1'b1;
            hold_request = 1'b1;
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (ph == 5 && i == PHASE_ITEMS / 2) drain();
            if ($urandom_range(0, 15) == 0)
               send_item(start_item(16'($urandom), 16'($urandom)));
            else
               send_item(decode_item(random_window()));
         end
         drain();
      end

      if (mirror.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
